### rtl/hta_pkg.sv
// ----------------------------------------------------------------------------
// hta_pkg: shared types and constants for the triangle area summer
// Widths, register indexes, controller states and the command/status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package hta_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_LIST  = 4096;
    localparam int DEF_SIDE_BITS = 12;

    // Fixed field widths
    localparam int SCALE_W   = 4;
    localparam int TOTAL_W   = 48;
    localparam int IDX_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = SCALE_W;

    // Product is built from chunks of this many multiplier bits per cycle
    localparam int MUL_CHUNK = 16;

    localparam logic [TOTAL_W-1:0] SUM_MAX = {TOTAL_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_C = 2'd2;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_SQRT,
        ST_ACC
    } hta_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;       // capture a beat and scale its sides
        logic calc_p;     // form the two half products, clear root unit
        logic mul_step;   // one chunk of the full product
        logic sqrt_step;  // one root bit
        logic list_drop;  // item of a failed list
        logic list_err;   // emit error result
        logic accum;      // add area, emit total on last
    } hta_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic skipping;
        logic bad;
        logic last;
        logic out_busy;
    } hta_status_t;

    // Width of the full radicand, rounded up to even
    function automatic int hta_prod_w(input int side_bits);
        int sw;
        int pw;
        sw = side_bits + SCALE_W;
        pw = (sw + 2) + (sw + 1) + 2 * (sw + 1);
        return pw + (pw & 1);
    endfunction

    // Number of chunk multiply steps
    function automatic int hta_mul_steps(input int side_bits);
        int p2w;
        p2w = 2 * (side_bits + SCALE_W + 1);
        return (p2w + MUL_CHUNK - 1) / MUL_CHUNK;
    endfunction

endpackage

### rtl/hta_ctrl.sv
// ----------------------------------------------------------------------------
// hta_ctrl: sequencing controller
// Steps one triangle through check, chunked multiply, bit-serial square
// root and accumulate, and holds results until the output slot is free.
// ----------------------------------------------------------------------------
module hta_ctrl #(
    parameter int MUL_STEPS  = 3,
    parameter int SQRT_STEPS = 35
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hta_pkg::hta_status_t stat,
    output hta_pkg::hta_cmd_t    cmd
);
    import hta_pkg::*;

    localparam int MAX_STEPS = (MUL_STEPS > SQRT_STEPS) ? MUL_STEPS : SQRT_STEPS;
    localparam int CW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    hta_state_t    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          mul_done, sqrt_done;

    assign mul_done  = (cnt_reg == CW'(MUL_STEPS - 1));
    assign sqrt_done = (cnt_reg == CW'(SQRT_STEPS - 1));

    // State register and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_PREP;
            end
            ST_PREP: begin
                if (stat.skipping) begin
                    state_next = ST_IDLE;
                end else if (stat.bad) begin
                    if (!stat.out_busy) state_next = ST_IDLE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (sqrt_done) state_next = ST_ACC;
            end
            ST_ACC: begin
                if (!stat.last || !stat.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Step counter: cleared on entry to each iterating state
    always_comb begin
        cnt_next = '0;
        case (state_reg)
            ST_MUL:  cnt_next = mul_done  ? '0 : cnt_reg + 1'b1;
            ST_SQRT: cnt_next = sqrt_done ? '0 : cnt_reg + 1'b1;
            default: cnt_next = '0;
        endcase
    end

    // Commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_PREP: begin
                if (stat.skipping) begin
                    cmd.list_drop = 1'b1;
                end else if (stat.bad) begin
                    cmd.list_err = !stat.out_busy;
                end else begin
                    cmd.calc_p = 1'b1;
                end
            end
            ST_MUL:  cmd.mul_step  = 1'b1;
            ST_SQRT: cmd.sqrt_step = 1'b1;
            ST_ACC:  cmd.accum     = !stat.last || !stat.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

### rtl/hta_datapath.sv
// ----------------------------------------------------------------------------
// hta_datapath: arithmetic and list state
// Side scaling, triangle check, chunked product, restoring square root,
// saturating total, list index and the output register.
// ----------------------------------------------------------------------------
module hta_datapath #(
    parameter int MAX_LIST  = 4096,
    parameter int SIDE_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [hta_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hta_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input beat
    input  logic [SIDE_BITS-1:0]                s_side_a,
    input  logic [SIDE_BITS-1:0]                s_side_b,
    input  logic [SIDE_BITS-1:0]                s_side_c,
    input  logic                                s_last,
    // result beat
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hta_pkg::TOTAL_W-1:0]         m_total,
    output logic                                m_status,
    output logic [hta_pkg::IDX_W-1:0]           m_bad_index,
    // controller
    input  hta_pkg::hta_cmd_t                   cmd,
    output hta_pkg::hta_status_t                stat
);
    import hta_pkg::*;

    localparam int SW    = SIDE_BITS + SCALE_W;     // scaled side
    localparam int DW    = SW + 1;                  // pair sum / difference
    localparam int SUMW  = SW + 2;                  // perimeter
    localparam int P1W   = SUMW + DW;
    localparam int P2W   = 2 * DW;
    localparam int NCH   = hta_mul_steps(SIDE_BITS);
    localparam int P2XW  = NCH * MUL_CHUNK;
    localparam int PW    = hta_prod_w(SIDE_BITS);
    localparam int RW    = PW / 2;
    localparam int AW    = ((RW > TOTAL_W) ? RW : TOTAL_W) + 1;
    localparam int CNT_W = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
    localparam int PARTW = P1W + MUL_CHUNK;

    logic [SCALE_W-1:0] scale_a_reg, scale_b_reg, scale_c_reg;
    logic [SW-1:0]      sa_reg, sb_reg, sc_reg;
    logic               last_reg;
    logic [P1W-1:0]     p1_reg;
    logic [P2XW-1:0]    p2_reg;
    logic [PW-1:0]      acc_reg;
    logic [RW+1:0]      rem_reg;
    logic [RW-1:0]      root_reg;
    logic [TOTAL_W-1:0] area_sum_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               skipping_reg;
    logic               m_valid_reg;
    logic [TOTAL_W-1:0] m_total_reg;
    logic               m_status_reg;
    logic [IDX_W-1:0]   m_bad_index_reg;

    logic [DW-1:0]      sum_ab, sum_ac, sum_bc;
    logic [SUMW-1:0]    perim;
    logic [DW-1:0]      d_a, d_b, d_c;
    logic               bad;
    logic [PARTW-1:0]   part;
    logic [RW+3:0]      rem_t, trial;
    logic [AW-1:0]      sum_ext;
    logic [TOTAL_W-1:0] sum_sat;
    logic [CNT_W+IDX_W-1:0] idx_ext;
    logic               out_busy;

    // Triangle check and half-product terms
    assign sum_ab = DW'(sa_reg) + DW'(sb_reg);
    assign sum_ac = DW'(sa_reg) + DW'(sc_reg);
    assign sum_bc = DW'(sb_reg) + DW'(sc_reg);
    assign perim  = SUMW'(sa_reg) + SUMW'(sb_reg) + SUMW'(sc_reg);
    assign d_a    = sum_bc - DW'(sa_reg);
    assign d_b    = sum_ac - DW'(sb_reg);
    assign d_c    = sum_ab - DW'(sc_reg);
    assign bad    = !((sum_ab > DW'(sc_reg)) && (sum_ac > DW'(sb_reg)) &&
                      (sum_bc > DW'(sa_reg)));

    // One chunk of the full product, top chunk first
    assign part = PARTW'(p1_reg) * PARTW'(p2_reg[P2XW-1 -: MUL_CHUNK]);

    // Restoring root step: bring down two radicand bits
    assign rem_t = {rem_reg, acc_reg[PW-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};

    // Saturating add of the area
    assign sum_ext = AW'(area_sum_reg) + AW'(root_reg);
    assign sum_sat = (sum_ext > AW'(SUM_MAX)) ? SUM_MAX : sum_ext[TOTAL_W-1:0];

    // Error index: low bits of the list position
    assign idx_ext = {{IDX_W{1'b0}}, count_reg};

    assign out_busy = m_valid_reg && !m_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_a_reg <= SCALE_W'(1);
            scale_b_reg <= SCALE_W'(1);
            scale_c_reg <= SCALE_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCALE_A: scale_a_reg <= cfg_data;
                REG_SCALE_B: scale_b_reg <= cfg_data;
                REG_SCALE_C: scale_c_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Working registers: scaled sides, product, root
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sa_reg   <= SW'(s_side_a) * SW'(scale_a_reg);
            sb_reg   <= SW'(s_side_b) * SW'(scale_b_reg);
            sc_reg   <= SW'(s_side_c) * SW'(scale_c_reg);
            last_reg <= s_last;
        end
        if (cmd.calc_p) begin
            p1_reg   <= P1W'(perim) * P1W'(d_a);
            p2_reg   <= P2XW'(P2W'(d_b) * P2W'(d_c));
            acc_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.mul_step) begin
            acc_reg <= (acc_reg << MUL_CHUNK) + PW'(part);
            p2_reg  <= p2_reg << MUL_CHUNK;
        end
        if (cmd.sqrt_step) begin
            acc_reg <= acc_reg << 2;
            if (rem_t >= trial) begin
                rem_reg  <= (RW + 2)'(rem_t - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_t[RW+1:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    // List state: running total, position, drop flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_sum_reg <= '0;
            count_reg    <= '0;
            skipping_reg <= 1'b0;
        end else if (cmd.list_drop) begin
            if (last_reg) begin
                area_sum_reg <= '0;
                count_reg    <= '0;
                skipping_reg <= 1'b0;
            end
        end else if (cmd.list_err) begin
            area_sum_reg <= '0;
            count_reg    <= '0;
            skipping_reg <= !last_reg;
        end else if (cmd.accum) begin
            if (last_reg) begin
                area_sum_reg <= '0;
                count_reg    <= '0;
            end else begin
                area_sum_reg <= sum_sat;
                if (count_reg == CNT_W'(MAX_LIST - 1)) count_reg <= '0;
                else                                   count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Output slot: valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.list_err || (cmd.accum && last_reg)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output slot: result payload
    always_ff @(posedge aclk) begin
        if (cmd.list_err) begin
            m_total_reg     <= '0;
            m_status_reg    <= STATUS_BAD;
            m_bad_index_reg <= idx_ext[IDX_W-1:0];
        end else if (cmd.accum && last_reg) begin
            m_total_reg     <= sum_sat;
            m_status_reg    <= STATUS_OK;
            m_bad_index_reg <= '0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_total     = m_total_reg;
    assign m_status    = m_status_reg;
    assign m_bad_index = m_bad_index_reg;

    assign stat.skipping = skipping_reg;
    assign stat.bad      = bad;
    assign stat.last     = last_reg;
    assign stat.out_busy = out_busy;

endmodule

### rtl/heron_triangle_area_sum.sv
// A good item passes from PREP through MUL and SQRT to ACC, where the total of a
//   last item goes to the output slot; an error result goes there from PREP.
// A new item is accepted only in IDLE, after the previous one is through; the root
//   is found bit-serially, one root bit per cycle.
// Reset: aresetn is synchronous, active low; scales return to 1, total, index and
//   drop flag clear, and any pending result is discarded.
// ----------------------------------------------------------------------------
// heron_triangle_area_sum: list sum of triangle areas by Heron's formula
// Scales each side, checks the strict triangle inequality and adds
// floor(sqrt(product of the four Heron terms)) to a saturating 48-bit total.
// ----------------------------------------------------------------------------
module heron_triangle_area_sum #(
    parameter int MAX_LIST  = hta_pkg::DEF_MAX_LIST,
    parameter int SIDE_BITS = hta_pkg::DEF_SIDE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [hta_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hta_pkg::CFG_DATA_W-1:0]  cfg_data,
    // triangle beats
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [SIDE_BITS-1:0]            s_side_a,
    input  logic [SIDE_BITS-1:0]            s_side_b,
    input  logic [SIDE_BITS-1:0]            s_side_c,
    input  logic                            s_last,
    // result beats
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [hta_pkg::TOTAL_W-1:0]     m_total,
    output logic                            m_status,
    output logic [hta_pkg::IDX_W-1:0]       m_bad_index
);
    import hta_pkg::*;

    localparam int MUL_STEPS  = hta_mul_steps(SIDE_BITS);
    localparam int SQRT_STEPS = hta_prod_w(SIDE_BITS) / 2;

    hta_cmd_t    cmd;
    hta_status_t stat;

    hta_ctrl #(
        .MUL_STEPS  (MUL_STEPS),
        .SQRT_STEPS (SQRT_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hta_datapath #(
        .MAX_LIST  (MAX_LIST),
        .SIDE_BITS (SIDE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_side_a    (s_side_a),
        .s_side_b    (s_side_b),
        .s_side_c    (s_side_c),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_total     (m_total),
        .m_status    (m_status),
        .m_bad_index (m_bad_index),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
